[design/ter_pkg.sv]
`default_nettype none
package ter_pkg;

    localparam int SUB_BITS    = 4;
    localparam int SUB_HALF    = (1 << SUB_BITS) >> 1;
    localparam int MAX_SCREEN  = 2048;
    localparam int COORD_W     = 15;
    localparam int POS_W       = 11;
    localparam int STEP_W      = 18;
    localparam int EDGE_W      = 40;
    localparam int AREA_W      = 33;
    localparam int COLOR_W     = 24;
    localparam int DIM_W       = 12;
    localparam int ADDR_W      = 22;
    localparam int INV_W       = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [7:0] CFG_SCREEN_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_SCREEN_HEIGHT = 8'd1;

    typedef struct packed {
        logic                          cmd;
        logic [2:0][COLOR_W-1:0]       color;
        logic [2:0][COORD_W-1:0]       vy;
        logic [2:0][COORD_W-1:0]       vx;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic [POS_W-1:0]   pixel_x;
        logic [POS_W-1:0]   pixel_row;
        logic [ADDR_W-1:0]  pixel_address;
        logic               covered;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last;
    } pixel_t;

endpackage
`default_nettype wire

[design/ter_queue.sv]
`default_nettype none
module ter_queue
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  ter_pkg::item_t    push_item,
    input  wire               pop,
    output ter_pkg::item_t    head_item,
    output ter_pkg::queue_status_t status
);

    ter_pkg::item_t entry_reg [ter_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'(ter_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_item    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule
`default_nettype wire

[design/ter_div.sv]
`default_nettype none
module ter_div
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    input  wire [31:0] divisor,
    output logic       busy,
    output logic [31:0] quotient
);

    // restoring divide of all-ones by divisor, one quotient bit per cycle
    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] div_reg;
    logic [5:0]  count_reg;
    logic        busy_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial    = {rem_reg[31:0], 1'b1};
    assign fits     = trial >= {1'b0, div_reg};
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= 6'd0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= 6'd0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 6'd1;
            if (count_reg == 6'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 33'd0;
            quo_reg <= 32'd0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

endmodule
`default_nettype wire

[design/ter_engine.sv]
`default_nettype none
module ter_engine
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  ter_pkg::item_t              head_item,
    input  ter_pkg::queue_status_t      q_status,
    output logic                        pop,
    input  wire [ter_pkg::DIM_W-1:0]    screen_width,
    input  wire [ter_pkg::DIM_W-1:0]    screen_height,
    output logic                        out_valid,
    input  wire                         out_ready,
    output ter_pkg::pixel_t             out_pixel
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_BOX,
        ST_EDGE,
        ST_DIV,
        ST_SCALE,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [2:0][ter_pkg::COORD_W-1:0]        vx_reg, vy_reg;
    logic [2:0][ter_pkg::COLOR_W-1:0]        color_reg;
    logic signed [ter_pkg::STEP_W-1:0]       a_reg [3];
    logic signed [ter_pkg::STEP_W-1:0]       b_reg [3];
    logic signed [ter_pkg::EDGE_W-1:0]       row_start_reg [3];
    logic signed [ter_pkg::EDGE_W-1:0]       cur_reg [3];
    logic signed [ter_pkg::AREA_W-1:0]       area_reg;
    logic [ter_pkg::INV_W-1:0]               inv_reg;
    logic [ter_pkg::POS_W-1:0]               xmin_reg, ymin_reg, xmax_reg, ymax_reg;
    logic [ter_pkg::POS_W-1:0]               j_reg, i_reg;
    logic                                    active_reg;
    logic [1:0]                              k_reg;
    logic [31:0]                             p0_reg, p1_reg;
    logic                                    cov_reg;
    logic signed [41:0]                      t0_reg [3];
    logic signed [41:0]                      t1_reg [3];
    logic                                    out_valid_reg;
    ter_pkg::pixel_t                         out_reg;

    logic                                    div_start;
    logic                                    div_busy;
    logic [31:0]                             div_q;

    logic signed [ter_pkg::STEP_W-1:0]       a_new [3];
    logic signed [ter_pkg::STEP_W-1:0]       b_new [3];
    logic signed [ter_pkg::AREA_W-1:0]       area_calc;
    logic [ter_pkg::COORD_W-1:0]             xlo, xhi, ylo, yhi;
    logic [15:0]                             px, py;
    logic [1:0]                              pidx;
    logic signed [17:0]                      dx, dy;
    logic signed [ter_pkg::EDGE_W-1:0]       edge_val;
    logic                                    cov;
    logic [2:0]                              pass;
    logic                                    out_free;
    logic [ter_pkg::POS_W:0]                 j_inc;
    logic                                    col_more;
    logic                                    row_more;
    logic [ter_pkg::POS_W-1:0]               row;
    logic [22:0]                             addr_full;
    logic [2:0][7:0]                         shade;
    logic signed [42:0]                      acc [3];
    logic signed [42:0]                      rnd [3];

    function automatic logic [ter_pkg::POS_W-1:0] round_coord(
        input logic [ter_pkg::COORD_W-1:0] v);
        logic [15:0] r;
        r = (16'(v) + 16'(ter_pkg::SUB_HALF)) >> ter_pkg::SUB_BITS;
        if (r > 16'(ter_pkg::MAX_SCREEN - 1))
        begin
            r = 16'(ter_pkg::MAX_SCREEN - 1);
        end
        return r[ter_pkg::POS_W-1:0];
    endfunction

    ter_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (area_reg[31:0]),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign pop       = (state_reg == ST_IDLE) && !q_status.empty;
    assign div_start = (state_reg == ST_BOX) && (area_reg > 0);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_pixel = out_reg;

    // edge k runs from vertex k+1 to vertex k+2
    always_comb
    begin
        a_new[0] = $signed({3'b0, head_item.vy[1]}) - $signed({3'b0, head_item.vy[2]});
        b_new[0] = $signed({3'b0, head_item.vx[2]}) - $signed({3'b0, head_item.vx[1]});
        a_new[1] = $signed({3'b0, head_item.vy[2]}) - $signed({3'b0, head_item.vy[0]});
        b_new[1] = $signed({3'b0, head_item.vx[0]}) - $signed({3'b0, head_item.vx[2]});
        a_new[2] = $signed({3'b0, head_item.vy[0]}) - $signed({3'b0, head_item.vy[1]});
        b_new[2] = $signed({3'b0, head_item.vx[1]}) - $signed({3'b0, head_item.vx[0]});
    end

    assign area_calc =
        ter_pkg::AREA_W'(a_reg[0] * ($signed({3'b0, vx_reg[0]}) - $signed({3'b0, vx_reg[1]})))
      + ter_pkg::AREA_W'(b_reg[0] * ($signed({3'b0, vy_reg[0]}) - $signed({3'b0, vy_reg[1]})));

    always_comb
    begin
        xlo = vx_reg[0];
        xhi = vx_reg[0];
        ylo = vy_reg[0];
        yhi = vy_reg[0];
        for (int v = 1; v < 3; v++)
        begin
            if (vx_reg[v] < xlo) xlo = vx_reg[v];
            if (vx_reg[v] > xhi) xhi = vx_reg[v];
            if (vy_reg[v] < ylo) ylo = vy_reg[v];
            if (vy_reg[v] > yhi) yhi = vy_reg[v];
        end
    end

    always_comb
    begin
        case (k_reg)
            2'd0:    pidx = 2'd1;
            2'd1:    pidx = 2'd2;
            default: pidx = 2'd0;
        endcase
    end

    assign px = (16'(xmin_reg) << ter_pkg::SUB_BITS) + 16'(ter_pkg::SUB_HALF);
    assign py = (16'(ymax_reg) << ter_pkg::SUB_BITS) - 16'(ter_pkg::SUB_HALF);
    assign dx = $signed({2'b0, px}) - $signed({3'b0, vx_reg[pidx]});
    assign dy = $signed({2'b0, py}) - $signed({3'b0, vy_reg[pidx]});
    assign edge_val = ter_pkg::EDGE_W'(a_reg[k_reg] * dx)
                    + ter_pkg::EDGE_W'(b_reg[k_reg] * dy);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pass[k] = (cur_reg[k] > 0)
                   || ((cur_reg[k] == 0)
                       && ((a_reg[k] > 0) || ((a_reg[k] == 0) && (b_reg[k] < 0))));
        end
        cov = &pass;
    end

    assign j_inc     = {1'b0, j_reg} + 12'd1;
    assign col_more  = j_inc < {1'b0, xmax_reg};
    assign row_more  = (i_reg - 11'd1) > ymin_reg;
    assign row       = ter_pkg::POS_W'(screen_height - {1'b0, i_reg});
    assign addr_full = 23'(row * screen_width) + 23'(j_reg);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = $signed({3'b0, color_reg[2][c*8 +: 8], 32'b0})
                   + 43'(t0_reg[c]) + 43'(t1_reg[c]);
            rnd[c] = (acc[c] + 43'sd2147483648) >>> 32;
            if (acc[c] < 0)
            begin
                shade[c] = 8'd0;
            end
            else if (rnd[c] > 43'sd255)
            begin
                shade[c] = 8'd255;
            end
            else
            begin
                shade[c] = rnd[c][7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= 2'd0;
        end
        else
        begin
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        if (head_item.cmd == ter_pkg::CMD_LOAD)
                        begin
                            vx_reg     <= head_item.vx;
                            vy_reg     <= head_item.vy;
                            color_reg  <= head_item.color;
                            for (int k = 0; k < 3; k++)
                            begin
                                a_reg[k] <= a_new[k];
                                b_reg[k] <= b_new[k];
                            end
                            active_reg <= 1'b0;
                            state_reg  <= ST_AREA;
                        end
                        else if (active_reg)
                        begin
                            p0_reg    <= 32'(cur_reg[0][31:0] * inv_reg);
                            p1_reg    <= 32'(cur_reg[1][31:0] * inv_reg);
                            cov_reg   <= cov;
                            state_reg <= ST_SCALE;
                        end
                    end
                end
                ST_AREA:
                begin
                    area_reg  <= area_calc;
                    state_reg <= ST_BOX;
                end
                ST_BOX:
                begin
                    xmin_reg <= round_coord(xlo);
                    ymin_reg <= round_coord(ylo);
                    xmax_reg <= round_coord(xhi);
                    ymax_reg <= round_coord(yhi);
                    k_reg    <= 2'd0;
                    state_reg <= (area_reg > 0) ? ST_EDGE : ST_IDLE;
                end
                ST_EDGE:
                begin
                    if (xmax_reg <= xmin_reg || ymax_reg <= ymin_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        row_start_reg[k_reg] <= edge_val;
                        cur_reg[k_reg]       <= edge_val;
                        k_reg                <= k_reg + 2'd1;
                        if (k_reg == 2'd2)
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (!div_busy)
                    begin
                        inv_reg    <= div_q;
                        j_reg      <= xmin_reg;
                        i_reg      <= ymax_reg;
                        active_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                ST_SCALE:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        t0_reg[c] <= $signed({1'b0, p0_reg})
                                   * ($signed({1'b0, color_reg[0][c*8 +: 8]})
                                      - $signed({1'b0, color_reg[2][c*8 +: 8]}));
                        t1_reg[c] <= $signed({1'b0, p1_reg})
                                   * ($signed({1'b0, color_reg[1][c*8 +: 8]})
                                      - $signed({1'b0, color_reg[2][c*8 +: 8]}));
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg.pixel_x       <= j_reg;
                        out_reg.pixel_row     <= row;
                        out_reg.pixel_address <= addr_full[ter_pkg::ADDR_W-1:0];
                        out_reg.covered       <= cov_reg;
                        out_reg.red           <= cov_reg ? shade[2] : 8'd0;
                        out_reg.green         <= cov_reg ? shade[1] : 8'd0;
                        out_reg.blue          <= cov_reg ? shade[0] : 8'd0;
                        out_reg.last          <= !col_more && !row_more;
                        if (col_more)
                        begin
                            j_reg <= j_inc[ter_pkg::POS_W-1:0];
                            for (int k = 0; k < 3; k++)
                            begin
                                cur_reg[k] <= cur_reg[k]
                                    + (ter_pkg::EDGE_W'(a_reg[k]) <<< ter_pkg::SUB_BITS);
                            end
                        end
                        else if (row_more)
                        begin
                            j_reg <= xmin_reg;
                            i_reg <= i_reg - 11'd1;
                            for (int k = 0; k < 3; k++)
                            begin
                                row_start_reg[k] <= row_start_reg[k]
                                    - (ter_pkg::EDGE_W'(b_reg[k]) <<< ter_pkg::SUB_BITS);
                                cur_reg[k] <= row_start_reg[k]
                                    - (ter_pkg::EDGE_W'(b_reg[k]) <<< ter_pkg::SUB_BITS);
                            end
                        end
                        else
                        begin
                            active_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[design/triangle_edge_rasterizer.sv]
`default_nettype none
// Edge-function triangle rasterizer with Gouraud shading. A load (tuser 0) sets
// up a triangle: the doubled area, culling, bounding box, an edge equation per edge
// and a reciprocal area from a bit-serial divider; unless culled, it keeps the engine
// busy until that divider is done. It emits nothing. Each step (tuser 1) walks one
// pixel of the box and offers one transfer once it has passed the two multiply stages
// of the color interpolator and the output register, which waits while the
// output stalls; the next item leaves the queue in the cycle after that register loads.
// A step with no active triangle is dropped. Input items wait in a two-entry
// queue, and the result sits in an output register, so both sides stall freely.
module triangle_edge_rasterizer
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, color0, color1, color2
    input  wire [167:0] s_tdata,
    // cmd
    input  wire [0:0]   s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // pixel_x, pixel_row, pixel_address, red, green, blue
    output logic [71:0] m_tdata,
    // covered
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_index,
    input  wire [11:0]  cfg_data
);

    logic [ter_pkg::DIM_W-1:0]  width_reg;
    logic [ter_pkg::DIM_W-1:0]  height_reg;
    ter_pkg::item_t             in_item;
    ter_pkg::item_t             head_item;
    ter_pkg::queue_status_t     q_status;
    ter_pkg::pixel_t            pixel;
    logic                       pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ter_pkg::CFG_SCREEN_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == ter_pkg::CFG_SCREEN_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        in_item.cmd = s_tuser[0];
        for (int v = 0; v < 3; v++)
        begin
            in_item.vx[v]    = s_tdata[v*30 +: 15];
            in_item.vy[v]    = s_tdata[v*30 + 15 +: 15];
            in_item.color[v] = s_tdata[90 + v*24 +: 24];
        end
    end

    assign s_tready = !q_status.full;

    ter_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_item (in_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    ter_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_item     (head_item),
        .q_status      (q_status),
        .pop           (pop),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_pixel     (pixel)
    );

    assign m_tdata = {4'b0, pixel.blue, pixel.green, pixel.red,
                      pixel.pixel_address, pixel.pixel_row, pixel.pixel_x};
    assign m_tuser = pixel.covered;
    assign m_tlast = pixel.last;

`ifndef SYNTH
    a_black_when_uncovered: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[67:44] == 24'd0)
        else $error("uncovered pixel carries color");

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire
